@@ design/fixed_block_free_list_core_assert.svh @@
// Assertion macros shared by the free list checker.
`ifndef FIXED_BLOCK_FREE_LIST_CORE_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_CORE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define FBFL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("free list check failed");

// Check cons in the cycle after ante.
`define FBFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("free list check failed");

`endif

@@ design/fbfl_pkg.sv @@
`timescale 1ns / 1ps
package fbfl_pkg;

	// Default pool size, one index past the last block is the null link
	localparam int MAX_BLOCKS_DEF = 256;

	// Fixed field widths
	localparam int IDX_W    = 8;
	localparam int CNT_W    = 9;
	localparam int ACT_W    = 2;
	localparam int IN_USR_W = ACT_W + 1;
	localparam int OUT_DW   = 24;

	// Free counter saturation value
	localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;

	// Action codes; code three is unused and rejected
	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_INIT  = 2'd2
	} action_t;

	// One result item
	typedef struct packed {
		logic [IDX_W-1:0] granted_index;
		logic             ok;
		logic [CNT_W-1:0] free_count;
	} res_t;

endpackage

@@ design/fbfl_link_mem.sv @@
`timescale 1ns / 1ps
module fbfl_link_mem #(
	parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF,
	parameter int AW = $clog2(MAX_BLOCKS),
	parameter int LW = $clog2(MAX_BLOCKS + 1)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [LW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [LW-1:0] rdata
);

	logic [LW-1:0] mem [MAX_BLOCKS];
	logic [LW-1:0] rdata_q;

	// Write one link per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/fbfl_ctrl.sv @@
`timescale 1ns / 1ps
module fbfl_ctrl #(
	parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF,
	parameter int AW = $clog2(MAX_BLOCKS),
	parameter int LW = $clog2(MAX_BLOCKS + 1),
	parameter int XW = (LW > fbfl_pkg::CNT_W) ? LW : fbfl_pkg::CNT_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  fbfl_pkg::action_t            in_action,
	input  logic [fbfl_pkg::IDX_W-1:0]   in_index,
	input  logic                         in_present,
	input  logic [XW-1:0]                block_count,
	output logic                         mem_we,
	output logic [AW-1:0]                mem_waddr,
	output logic [LW-1:0]                mem_wdata,
	output logic [AW-1:0]                mem_raddr,
	input  logic [LW-1:0]                mem_rdata,
	output logic                         res_valid,
	input  logic                         res_ready,
	output fbfl_pkg::res_t               res
);
	import fbfl_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_INIT
	} state_t;

	localparam logic [XW-1:0] NULL_X = XW'(MAX_BLOCKS);
	localparam logic [LW-1:0] NULL_L = LW'(MAX_BLOCKS);

	state_t           state_q;
	logic [LW-1:0]    head_q;
	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0]    walk_q;
	logic [AW-1:0]    last_q;
	logic             res_valid_q;
	res_t             res_q;

	logic             accept;
	logic [XW-1:0]    head_x;
	logic [XW-1:0]    idx_x;
	logic             head_null;
	logic             idx_ok;
	logic [XW-1:0]    n_x;
	logic [XW-1:0]    n_done;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] cnt_dec;
	logic [CNT_W-1:0] cnt_init;

	assign in_ready = (state_q == ST_IDLE) && (!res_valid_q || res_ready);
	assign accept   = in_valid && in_ready;

	// Decode head, index range and pool size
	always_comb begin
		head_x    = XW'(head_q);
		idx_x     = XW'(in_index);
		head_null = (head_x >= NULL_X);
		idx_ok    = (idx_x < NULL_X);
		if (block_count == '0) begin
			n_x = XW'(1);
		end else if (block_count > NULL_X) begin
			n_x = NULL_X;
		end else begin
			n_x = block_count;
		end
		n_done   = XW'(last_q) + XW'(1);
		cnt_init = (n_done > XW'(COUNT_MAX)) ? COUNT_MAX : n_done[CNT_W-1:0];
		cnt_inc  = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);
		cnt_dec  = (cnt_q == '0) ? cnt_q : cnt_q - CNT_W'(1);
	end

	// Link memory access: push on free, sweep on init, read at head
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_x[AW-1:0];
		mem_wdata = head_q;
		if (state_q == ST_INIT) begin
			mem_we    = 1'b1;
			mem_waddr = walk_q;
			mem_wdata = (walk_q == '0) ? NULL_L : LW'(walk_q - AW'(1));
		end else if (accept && in_action == ACT_FREE && in_present && idx_ok) begin
			mem_we = 1'b1;
		end
		mem_raddr = head_q[AW-1:0];
	end

	// Sequence actions and hold the pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= NULL_L;
			cnt_q       <= '0;
			walk_q      <= '0;
			last_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q.granted_index <= '0;
						res_q.ok            <= 1'b0;
						res_q.free_count    <= cnt_q;
						case (in_action)
							ACT_ALLOC: begin
								if (head_null) begin
									res_valid_q <= 1'b1;
								end else begin
									state_q <= ST_ALLOC;
								end
							end
							ACT_FREE: begin
								res_valid_q <= 1'b1;
								if (!in_present) begin
									res_q.ok <= 1'b1;
								end else if (idx_ok) begin
									head_q           <= idx_x[LW-1:0];
									cnt_q            <= cnt_inc;
									res_q.ok         <= 1'b1;
									res_q.free_count <= cnt_inc;
								end
							end
							ACT_INIT: begin
								state_q <= ST_INIT;
								walk_q  <= '0;
								last_q  <= AW'(n_x - XW'(1));
							end
							default: begin
								res_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_ALLOC: begin
					// Pop: link read of the old head is now valid
					head_q              <= mem_rdata;
					cnt_q               <= cnt_dec;
					res_q.granted_index <= head_x[IDX_W-1:0];
					res_q.ok            <= 1'b1;
					res_q.free_count    <= cnt_dec;
					res_valid_q         <= 1'b1;
					state_q             <= ST_IDLE;
				end
				ST_INIT: begin
					walk_q <= walk_q + AW'(1);
					if (walk_q == last_q) begin
						head_q              <= LW'(last_q);
						cnt_q               <= cnt_init;
						res_q.granted_index <= '0;
						res_q.ok            <= 1'b1;
						res_q.free_count    <= cnt_init;
						res_valid_q         <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ design/fbfl_out_stage.sv @@
`timescale 1ns / 1ps
module fbfl_out_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  fbfl_pkg::res_t              in_res,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [fbfl_pkg::OUT_DW-1:0] m_tdata,
	output logic                        m_tuser
);
	import fbfl_pkg::*;

	logic valid_q;
	res_t res_q;

	assign in_ready = !valid_q || m_tready;

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(OUT_DW - IDX_W - CNT_W){1'b0}}, res_q.free_count,
		res_q.granted_index};
	assign m_tuser  = res_q.ok;

endmodule

@@ design/fixed_block_free_list_core.sv @@
`timescale 1ns / 1ps
// Free list manager for a pool of equal-size blocks named by index.
// Input stream: s_tuser selects the action (allocate, free, initialize) and
// whether a free carries a block; s_tdata carries the block index to free.
// Output stream: one transaction per input, with granted index, ok flag and
// the free count after the action.
// Configuration: cfg_valid/cfg_data write the block count used by the next
// initialize; write it only while the block is idle.
// Free and rejected actions need no extra state; allocate waits in ST_ALLOC
// for the link memory read before the head is updated; initialize stays in
// ST_INIT and writes the link memory one entry per cycle.
// No new input is taken until the current action is done; its result passes
// through the controller register and then the output register to m_tvalid.
// Reset leaves an empty list, a zero count and a block count of MAX_BLOCKS;
// the link memory is not cleared and is written before use.
// When the receiver stalls, one finished result waits in the output register
// and one more in the controller; input is held off only after that.
module fixed_block_free_list_core #(
	parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fbfl_pkg::IDX_W-1:0]    s_tdata,   // [7:0] block_index
	input  logic [fbfl_pkg::IN_USR_W-1:0] s_tuser,   // [1:0] action, [2] block_present
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fbfl_pkg::OUT_DW-1:0]   m_tdata,   // [7:0] granted_index,
	                                                 // [16:8] free_count, rest zero
	output logic                          m_tuser,   // [0] ok
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fbfl_pkg::CNT_W-1:0]    cfg_data
);
	import fbfl_pkg::*;

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int LW = $clog2(MAX_BLOCKS + 1);
	localparam int XW = (LW > CNT_W) ? LW : CNT_W;

	logic [XW-1:0] block_count_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [LW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [LW-1:0] mem_rdata;
	logic          res_valid;
	logic          res_ready;
	res_t          res;

	// Block count register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= XW'(MAX_BLOCKS);
		end else if (cfg_valid && cfg_ready) begin
			block_count_q <= XW'(cfg_data);
		end
	end

	fbfl_link_mem #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.AW(AW),
		.LW(LW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	fbfl_ctrl #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.AW(AW),
		.LW(LW),
		.XW(XW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_action(action_t'(s_tuser[ACT_W-1:0])),
		.in_index(s_tdata),
		.in_present(s_tuser[ACT_W]),
		.block_count(block_count_q),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	fbfl_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(res_valid),
		.in_ready(res_ready),
		.in_res(res),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

endmodule

@@ design/fbfl_checker.sv @@
`timescale 1ns / 1ps
`include "fixed_block_free_list_core_assert.svh"
module fbfl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [fbfl_pkg::OUT_DW-1:0]   m_tdata,
	input logic                          m_tuser
);
	import fbfl_pkg::*;

	logic       in_txn;
	logic       out_txn;
	logic [1:0] pend_q;

	assign in_txn  = s_tvalid && s_tready;
	assign out_txn = m_tvalid && m_tready;

	// Track inputs whose result is not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_txn && !out_txn) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_txn && !in_txn) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// A stalled result holds
	`FBFL_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		$stable(m_tdata) && $stable(m_tuser))

	// No result without an input in flight
	`FBFL_ASSERT_NOW(a_no_extra, clk, arst_n, m_tvalid, pend_q != 2'd0)

	// At most two items are in flight
	`FBFL_ASSERT_NOW(a_depth, clk, arst_n, in_txn || out_txn, pend_q != 2'd3)

	// A nonzero granted index only comes with ok
	`FBFL_ASSERT_NOW(a_grant_ok, clk, arst_n, m_tvalid && (m_tdata[IDX_W-1:0] != '0), m_tuser)

endmodule

bind fixed_block_free_list_core fbfl_checker u_fbfl_checker (.*);
